// ===== rtl/rpb_pkg.sv =====
// Shared types, constants and the blend weight function of the RGB555 pixel blender.
// Depends on nothing; every other file of the block imports it.
package rpb_pkg;

   // Pixel layout: bit 15 opaque, then three 5-bit channels, blue in the low bits.
   localparam int PIXEL_W   = 16;
   localparam int CHAN_W    = 5;
   localparam int CHANNELS  = 3;
   localparam int WIDE_W    = 8;
   localparam int TINTED_W  = WIDE_W + 1;
   localparam int PROD_W    = 2 * WIDE_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int SUM_SHIFT = 11;
   localparam int TINT_SHIFT = 7;
   localparam int OPAQUE_BIT = PIXEL_W - 1;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = CHANNELS * WIDE_W;
   localparam int MODE_W      = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_MODE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BLEND        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSPARENCY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_ALPHA    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_ALPHA    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TINT         = 3'd6;

   // Factor modes; the one remaining code, 7, selects full weight like FACTOR_ONE.
   localparam logic [MODE_W-1:0] FACTOR_ALPHA     = 3'd0;
   localparam logic [MODE_W-1:0] FACTOR_SRC       = 3'd1;
   localparam logic [MODE_W-1:0] FACTOR_DST       = 3'd2;
   localparam logic [MODE_W-1:0] FACTOR_ONE       = 3'd3;
   localparam logic [MODE_W-1:0] FACTOR_INV_ALPHA = 3'd4;
   localparam logic [MODE_W-1:0] FACTOR_INV_SRC   = 3'd5;
   localparam logic [MODE_W-1:0] FACTOR_INV_DST   = 3'd6;

   localparam logic [CSR_DATA_W-1:0] NO_TINT      = 24'h808080;
   localparam logic [WIDE_W-1:0]     OPAQUE_ALPHA = 8'h1f;
   localparam logic [WIDE_W-1:0]     FULL_WEIGHT  = 8'hff;
   localparam logic [CHAN_W-1:0]     CHAN_MAX     = 5'h1f;

   // Configuration as seen by the pipeline, with the derived flags.
   typedef struct packed {
      logic [MODE_W-1:0]     src_mode;
      logic [MODE_W-1:0]     dst_mode;
      logic                  blend_on;
      logic                  transparency_on;
      logic [WIDE_W-1:0]     src_level;
      logic [WIDE_W-1:0]     dst_level;
      logic [CSR_DATA_W-1:0] tint;
      logic                  tinted;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] source_pixel;
      logic [PIXEL_W-1:0] dest_pixel;
   } req_type;

   // After the tint stage.
   typedef struct packed {
      logic [CHANNELS-1:0][TINTED_W-1:0] tinted_src;
      logic [CHANNELS-1:0][CHAN_W-1:0]   dst_chan;
      logic                              opaque;
      logic                              keep;
      logic [PIXEL_W-1:0]                dest_pixel;
   } tint_type;

   // After the weighting stage.
   typedef struct packed {
      logic [CHANNELS-1:0][PROD_W-1:0]   src_prod;
      logic [CHANNELS-1:0][PROD_W-1:0]   dst_prod;
      logic [CHANNELS-1:0][TINTED_W-1:0] tinted_src;
      logic                              opaque;
      logic                              keep;
      logic [PIXEL_W-1:0]                dest_pixel;
   } weight_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] result_pixel;
      logic               kept_destination;
   } rsp_type;

   // Weight picked by a factor mode from the constant alpha and both channels.
   function automatic logic [WIDE_W-1:0] blend_weight(
      input logic [MODE_W-1:0] mode,
      input logic [WIDE_W-1:0] alpha,
      input logic [WIDE_W-1:0] src,
      input logic [WIDE_W-1:0] dst
   );
      logic [WIDE_W-1:0] w;
      case (mode)
         FACTOR_ALPHA:     w = alpha;
         FACTOR_SRC:       w = src;
         FACTOR_DST:       w = dst;
         FACTOR_INV_ALPHA: w = alpha ^ FULL_WEIGHT;
         FACTOR_INV_SRC:   w = src ^ FULL_WEIGHT;
         FACTOR_INV_DST:   w = dst ^ FULL_WEIGHT;
         default:          w = FULL_WEIGHT;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/rpb_channels.sv =====
// Channel interfaces of the pixel blender: request, response and register write.
// Depends on rpb_pkg for the field widths.
interface rpb_req_if;
   import rpb_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] source_pixel;
   logic [PIXEL_W-1:0] dest_pixel;
   modport source (output valid, source_pixel, dest_pixel, input ready);
   modport sink (input valid, source_pixel, dest_pixel, output ready);
endinterface

interface rpb_rsp_if;
   import rpb_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] result_pixel;
   logic               kept_destination;
   modport source (output valid, result_pixel, kept_destination, input ready);
   modport sink (input valid, result_pixel, kept_destination, output ready);
endinterface

interface rpb_csr_if;
   import rpb_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rgb555_pixel_blender_unit.sv =====
// Top level of the RGB555 pixel blender: configuration registers and three pipeline stages.
// Depends on rpb_pkg, rpb_channels.sv, rpb_cfg_regs and the rpb_* stage modules.
//
// Usage: a request on req_bus carries one source and one destination ARGB1555 pixel;
// the composited pixel and a flag telling whether transparency kept the destination
// come back on rsp_bus in request order. Registers are written on csr_bus, which is
// always ready; write them only while no request is in flight.
// A response turns valid once its request has passed the tint, weight and mix registers.
// While rsp_bus is not stalled, one request is accepted every cycle: the stages are tint
// multiply, weight multiply, and sum/clamp, each ending in a register, with valid bits
// moving alongside the data.
// When the receiver holds rsp_bus.ready low the last stage keeps its response and the
// stall backs up stage by stage; req_bus.ready drops only when all three are full.
// Synchronous reset empties the pipeline and loads the register defaults (all zero,
// tint 0x808080, meaning no tint).
module rgb555_pixel_blender_unit (
   input logic     clock,
   input logic     reset,
   rpb_req_if.sink req_bus,
   rpb_rsp_if.source rsp_bus,
   rpb_csr_if.sink csr_bus
);
   import rpb_pkg::*;

   cfg_type    cfg;
   req_type    req_data;
   tint_type   tint_data;
   weight_type weight_data;
   rsp_type    rsp_data;
   logic       tint_valid;
   logic       tint_ready;
   logic       weight_valid;
   logic       weight_ready;

   rpb_cfg_regs u_cfg_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   assign req_data.source_pixel = req_bus.source_pixel;
   assign req_data.dest_pixel   = req_bus.dest_pixel;

   rpb_tint_stage u_tint_stage (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_data),
      .out_valid (tint_valid),
      .out_ready (tint_ready),
      .out_data  (tint_data)
   );

   rpb_weight_stage u_weight_stage (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (tint_valid),
      .in_ready  (tint_ready),
      .in_data   (tint_data),
      .out_valid (weight_valid),
      .out_ready (weight_ready),
      .out_data  (weight_data)
   );

   rpb_mix_stage u_mix_stage (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (weight_valid),
      .in_ready  (weight_ready),
      .in_data   (weight_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.result_pixel     = rsp_data.result_pixel;
   assign rsp_bus.kept_destination = rsp_data.kept_destination;

   // An accepted request always lands in the first stage.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> tint_valid)
      else $error("accepted request did not reach the tint stage");

   // The destination can only be kept while transparency is on.
   a_keep_needs_transparency: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kept_destination) |-> cfg.transparency_on)
      else $error("destination kept with transparency off");

   // With transparency on, every composited pixel comes from an opaque source.
   a_composited_is_opaque: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.kept_destination && cfg.transparency_on)
         |-> rsp_bus.result_pixel[OPAQUE_BIT])
      else $error("transparent source composited instead of kept");

   // A full pipeline with a stalled receiver must refuse requests.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready && weight_valid && tint_valid) |-> !req_bus.ready)
      else $error("request taken while the pipeline is full and stalled");

endmodule

// ===== rtl/rpb_cfg_regs.sv =====
// Configuration registers of the pixel blender and the flags derived from them.
// Depends on rpb_pkg and the csr interface in rpb_channels.sv.
module rpb_cfg_regs (
   input  logic            clock,
   input  logic            reset,
   rpb_csr_if.sink         csr_bus,
   output rpb_pkg::cfg_type cfg
);
   import rpb_pkg::*;

   logic [MODE_W-1:0]     src_mode_ff;
   logic [MODE_W-1:0]     dst_mode_ff;
   logic                  blend_ff;
   logic                  transparency_ff;
   logic [WIDE_W-1:0]     src_level_ff;
   logic [WIDE_W-1:0]     dst_level_ff;
   logic [CSR_DATA_W-1:0] tint_ff;
   logic                  write_en;
   logic                  opaque_pair;

   // Writes are always taken.
   assign csr_bus.ready = 1'b1;
   assign write_en = csr_bus.valid && csr_bus.ready;

   // Register writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_mode_ff     <= '0;
         dst_mode_ff     <= '0;
         blend_ff        <= 1'b0;
         transparency_ff <= 1'b0;
         src_level_ff    <= '0;
         dst_level_ff    <= '0;
         tint_ff         <= NO_TINT;
      end else if (write_en) begin
         case (csr_bus.index)
            REG_SRC_MODE:     src_mode_ff     <= csr_bus.data[MODE_W-1:0];
            REG_DST_MODE:     dst_mode_ff     <= csr_bus.data[MODE_W-1:0];
            REG_BLEND:        blend_ff        <= csr_bus.data[0];
            REG_TRANSPARENCY: transparency_ff <= csr_bus.data[0];
            REG_SRC_ALPHA:    src_level_ff    <= csr_bus.data[WIDE_W-1:0];
            REG_DST_ALPHA:    dst_level_ff    <= csr_bus.data[WIDE_W-1:0];
            REG_TINT:         tint_ff         <= csr_bus.data;
            default:          ;
         endcase
      end
   end

   // The constant-alpha opaque pair turns blending off.
   assign opaque_pair = (src_mode_ff == FACTOR_ALPHA) && (src_level_ff == OPAQUE_ALPHA) &&
                        (dst_mode_ff == FACTOR_INV_ALPHA) && (dst_level_ff == OPAQUE_ALPHA);

   always_comb begin
      cfg.src_mode        = src_mode_ff;
      cfg.dst_mode        = dst_mode_ff;
      cfg.blend_on        = blend_ff && !opaque_pair;
      cfg.transparency_on = transparency_ff;
      cfg.src_level       = src_level_ff;
      cfg.dst_level       = dst_level_ff;
      cfg.tint            = tint_ff;
      cfg.tinted          = (tint_ff != NO_TINT);
   end

endmodule

// ===== rtl/rpb_tint_stage.sv =====
// First pipeline stage: widens the source channels and applies the tint.
// Depends on rpb_pkg.
module rpb_tint_stage (
   input  logic             clock,
   input  logic             reset,
   input  rpb_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  rpb_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rpb_pkg::tint_type out_data
);
   import rpb_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   tint_type data_ff;
   tint_type data_in;

   // The stage takes a new request when empty or when its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Per channel: c<<3, then (c8 * tint) >> 7 when a tint is set.
   always_comb begin
      logic [WIDE_W-1:0] src8;
      logic [PROD_W-1:0] prod;
      for (int i = 0; i < CHANNELS; i++) begin
         src8 = {in_data.source_pixel[CHAN_W*i +: CHAN_W], {(WIDE_W-CHAN_W){1'b0}}};
         prod = PROD_W'(src8) * PROD_W'(cfg.tint[WIDE_W*i +: WIDE_W]);
         data_in.tinted_src[i] = cfg.tinted ? prod[TINT_SHIFT +: TINTED_W]
                                            : {1'b0, src8};
         data_in.dst_chan[i]   = in_data.dest_pixel[CHAN_W*i +: CHAN_W];
      end
      data_in.opaque     = in_data.source_pixel[OPAQUE_BIT];
      data_in.keep       = cfg.transparency_on && !in_data.source_pixel[OPAQUE_BIT];
      data_in.dest_pixel = in_data.dest_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rpb_weight_stage.sv =====
// Second pipeline stage: clamps the tinted source and multiplies both sides by their weights.
// Depends on rpb_pkg.
module rpb_weight_stage (
   input  logic               clock,
   input  logic               reset,
   input  rpb_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  rpb_pkg::tint_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rpb_pkg::weight_type out_data
);
   import rpb_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   weight_type data_ff;
   weight_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Six independent 8x8 products, two per channel.
   always_comb begin
      logic [WIDE_W-1:0] src_clamp;
      logic [WIDE_W-1:0] dst8;
      logic [WIDE_W-1:0] src_w;
      logic [WIDE_W-1:0] dst_w;
      for (int i = 0; i < CHANNELS; i++) begin
         src_clamp = in_data.tinted_src[i][WIDE_W] ? FULL_WEIGHT
                                                   : in_data.tinted_src[i][WIDE_W-1:0];
         dst8  = {in_data.dst_chan[i], {(WIDE_W-CHAN_W){1'b0}}};
         src_w = blend_weight(cfg.src_mode, cfg.src_level, src_clamp, dst8);
         dst_w = blend_weight(cfg.dst_mode, cfg.dst_level, src_clamp, dst8);
         data_in.src_prod[i] = PROD_W'(src_clamp) * PROD_W'(src_w);
         data_in.dst_prod[i] = PROD_W'(dst8) * PROD_W'(dst_w);
      end
      data_in.tinted_src = in_data.tinted_src;
      data_in.opaque     = in_data.opaque;
      data_in.keep       = in_data.keep;
      data_in.dest_pixel = in_data.dest_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rpb_mix_stage.sv =====
// Last pipeline stage: saturating sum, final clamp and pixel assembly, held in the output register.
// Depends on rpb_pkg.
module rpb_mix_stage (
   input  logic                clock,
   input  logic                reset,
   input  rpb_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  rpb_pkg::weight_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rpb_pkg::rsp_type    out_data
);
   import rpb_pkg::*;

   localparam int NB_W = TINTED_W - (WIDE_W - CHAN_W);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Blend: sum saturates at 16 bits, then >> 11. Pass: tinted >> 3, clamped to 31.
   always_comb begin
      logic [SUM_W-1:0]  sum;
      logic [CHAN_W-1:0] mixed;
      logic [NB_W-1:0]   narrow;
      logic [CHAN_W-1:0] passed;
      data_in.result_pixel = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         sum    = SUM_W'(in_data.src_prod[i]) + SUM_W'(in_data.dst_prod[i]);
         mixed  = sum[SUM_W-1] ? CHAN_MAX : sum[SUM_SHIFT +: CHAN_W];
         narrow = in_data.tinted_src[i][TINTED_W-1 -: NB_W];
         passed = narrow[NB_W-1] ? CHAN_MAX : narrow[CHAN_W-1:0];
         data_in.result_pixel[CHAN_W*i +: CHAN_W] = cfg.blend_on ? mixed : passed;
      end
      data_in.result_pixel[OPAQUE_BIT] = in_data.opaque;
      if (in_data.keep) begin
         data_in.result_pixel = in_data.dest_pixel;
      end
      data_in.kept_destination = in_data.keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
